// File: rtl/core/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg: shared types for the nearest target search block
// Command, status and sequencer state codes used by the top level and the
// testbench.
// ----------------------------------------------------------------------------
package nts_pkg;

  // Command field of an input transfer.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOCK   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RETIRE = 2'd3
  } cmd_e;

  // Status field of a result transfer.
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2,
    STS_NONE  = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_RESP = 2'd2
  } state_e;

  // Width of the command, status and index fields.
  localparam int unsigned CmdW   = 2;
  localparam int unsigned IndexW = 8;
  localparam int unsigned PortCoordW = 16;

endpackage

// File: rtl/core/nts_dist.sv
// ----------------------------------------------------------------------------
// nts_dist: pipelined squared distance unit
// Takes one stored point per cycle and returns its exact squared Euclidean
// distance to the query, with its tag, via registered magnitude, square, sum.
// ----------------------------------------------------------------------------
module nts_dist #(
  parameter int CW = 16,
  parameter int AW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [AW-1:0]        idx_i,
  input  logic signed [CW-1:0] px_i,
  input  logic signed [CW-1:0] py_i,
  input  logic signed [CW-1:0] pz_i,
  input  logic signed [CW-1:0] qx_i,
  input  logic signed [CW-1:0] qy_i,
  input  logic signed [CW-1:0] qz_i,
  output logic                 valid_o,
  output logic [AW-1:0]        idx_o,
  output logic [2*CW+1:0]      dist_o,
  output logic                 busy_o
);

  localparam int DW = 2 * CW + 2;

  logic              s1_v_q, s2_v_q, s3_v_q;
  logic [AW-1:0]     s1_idx_q, s2_idx_q, s3_idx_q;
  logic [CW:0]       mag_x_d, mag_y_d, mag_z_d;
  logic [CW:0]       mag_x_q, mag_y_q, mag_z_q;
  logic [DW-1:0]     sq_x_q, sq_y_q, sq_z_q;
  logic [DW-1:0]     sum_q;
  logic signed [CW:0] dx, dy, dz;

  // Differences fit in CW+1 bits, so their magnitudes do too.
  always_comb begin
    dx = (CW+1)'(px_i) - (CW+1)'(qx_i);
    dy = (CW+1)'(py_i) - (CW+1)'(qy_i);
    dz = (CW+1)'(pz_i) - (CW+1)'(qz_i);
    mag_x_d = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
    mag_y_d = dy[CW] ? $unsigned(-dy) : $unsigned(dy);
    mag_z_d = dz[CW] ? $unsigned(-dz) : $unsigned(dz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= idx_i;
    mag_x_q  <= mag_x_d;
    mag_y_q  <= mag_y_d;
    mag_z_q  <= mag_z_d;
    s2_idx_q <= s1_idx_q;
    sq_x_q   <= DW'(mag_x_q) * DW'(mag_x_q);
    sq_y_q   <= DW'(mag_y_q) * DW'(mag_y_q);
    sq_z_q   <= DW'(mag_z_q) * DW'(mag_z_q);
    s3_idx_q <= s2_idx_q;
    sum_q    <= sq_x_q + sq_y_q + sq_z_q;
  end

  assign valid_o = s3_v_q;
  assign idx_o   = s3_idx_q;
  assign dist_o  = sum_q;
  assign busy_o  = s1_v_q | s2_v_q | s3_v_q;

endmodule

// File: rtl/core/nearest_target_search_top.sv
// ----------------------------------------------------------------------------
// nearest_target_search_top: table of 3D points with nearest target lock-on
// Holds up to MAX_ENTRIES points and a focus; insert, lock-on, clear, retire.
// ----------------------------------------------------------------------------
// Usage: one command enters per input transfer (in_valid_i / in_stall_o) and
// exactly one result leaves per output transfer (out_valid_o / out_stall_i).
// The block handles one command at a time and raises in_stall_o from the
// cycle after it takes a transfer until the result is loaded into the output
// register.
// Insert, clear and retire go through the response state straight into the
// output register. Lock-on first scans: the sequencer reads one stored point
// per cycle from the point memory, and each point goes through a three-stage
// squared distance pipeline and a running minimum. The memory read port is
// what sets the rate.
// The output is a single register: a new command is taken while a finished
// result still waits, but if the receiver keeps out_stall_i high the next
// result waits in the sequencer, and no further command is taken.
// Reset empties the table, drops the focus and clears the output valid flag.
// The point memory itself is not cleared; entries at or beyond the fill
// count are never scored.
// ----------------------------------------------------------------------------
module nearest_target_search_top #(
  parameter int MAX_ENTRIES = 256,
  parameter int COORD_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [nts_pkg::CmdW-1:0] cmd_i,
  input  logic signed [nts_pkg::PortCoordW-1:0] pos_x_i,
  input  logic signed [nts_pkg::PortCoordW-1:0] pos_y_i,
  input  logic signed [nts_pkg::PortCoordW-1:0] pos_z_i,
  input  logic        is_target_i,
  input  logic [nts_pkg::IndexW-1:0] entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [nts_pkg::CmdW-1:0] status_o,
  output logic [nts_pkg::IndexW-1:0] index_o,
  output logic        focus_valid_o
);

  localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int EW   = (CNTW > 8) ? CNTW : 8;
  localparam int CW   = COORD_BITS;
  localparam int PW   = (CW > 16) ? CW : 16;
  localparam int DW   = 2 * CW + 2;

  // Sequencer and architectural state.
  nts_pkg::state_e  state_q, state_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]    focus_q, focus_d;
  logic             held_q, held_d;
  logic [CNTW-1:0]  scan_q;

  // The command being worked on.
  nts_pkg::cmd_e    cmd_q;
  logic signed [CW-1:0] qx_q, qy_q, qz_q;
  logic             tgt_q;
  logic [7:0]       eidx_q;

  // Scan path.
  logic [3*CW-1:0]  pt_mem [MAX_ENTRIES];
  logic             flag_mem [MAX_ENTRIES];
  logic [3*CW-1:0]  rd_pt_q;
  logic             rd_flag_q;
  logic             rd_v_q;
  logic [AW-1:0]    rd_idx_q;
  logic [AW-1:0]    rd_addr;
  logic             issue_v;
  logic             scan_done;

  logic             dist_v;
  logic [AW-1:0]    dist_idx;
  logic [DW-1:0]    dist_val;
  logic             dist_busy;
  logic             found_q;
  logic [DW-1:0]    best_q;
  logic [AW-1:0]    best_idx_q;
  logic             better;

  // Handshake and response.
  logic             accept;
  logic             out_free;
  logic             resp_fire;
  logic             out_valid_q;
  nts_pkg::status_e out_status_q, resp_status;
  logic [7:0]       out_index_q, resp_index;
  logic             out_focus_q;

  logic             pt_we;
  logic             flag_we;
  logic [AW-1:0]    flag_wa;
  logic             flag_wd;
  logic             full;
  logic [EW-1:0]    eidx_w;
  logic             in_range;
  logic [PW-1:0]    ext_x, ext_y, ext_z;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (cnt_q == CNTW'(MAX_ENTRIES));
  assign eidx_w   = EW'(eidx_q);
  assign in_range = eidx_w < EW'(cnt_q);
  assign rd_addr  = AW'(scan_q);

  // The coordinate ports are taken as raw bits and reinterpreted as
  // two's complement numbers of COORD_BITS bits.
  assign ext_x = PW'($unsigned(pos_x_i));
  assign ext_y = PW'($unsigned(pos_y_i));
  assign ext_z = PW'($unsigned(pos_z_i));

  // Scan is over once every entry below the fill count has been read and the
  // distance pipeline has drained into the running minimum.
  assign scan_done = (scan_q == cnt_q) && !rd_v_q && !dist_busy;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (nts_pkg::cmd_e'(cmd_i) == nts_pkg::CMD_LOCK) ?
                    nts_pkg::S_SCAN : nts_pkg::S_RESP;
        end
      end
      nts_pkg::S_SCAN: begin
        if (scan_done) state_d = nts_pkg::S_RESP;
      end
      nts_pkg::S_RESP: begin
        if (out_free) state_d = nts_pkg::S_IDLE;
      end
      default: state_d = nts_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (state_q != nts_pkg::S_IDLE);
    issue_v    = (state_q == nts_pkg::S_SCAN) && (scan_q < cnt_q);
    resp_fire  = (state_q == nts_pkg::S_RESP) && out_free;
  end

  // Result of the command and its effect on the table and the focus.
  always_comb begin
    cnt_d       = cnt_q;
    focus_d     = focus_q;
    held_d      = held_q;
    resp_status = nts_pkg::STS_OK;
    pt_we       = 1'b0;
    flag_we     = 1'b0;
    flag_wa     = AW'(eidx_w);
    flag_wd     = 1'b0;
    unique case (cmd_q)
      nts_pkg::CMD_INSERT: begin
        if (full) begin
          resp_status = nts_pkg::STS_FULL;
        end else begin
          cnt_d   = cnt_q + CNTW'(1);
          pt_we   = resp_fire;
          flag_we = resp_fire;
          flag_wa = AW'(cnt_q);
          flag_wd = tgt_q;
        end
      end
      nts_pkg::CMD_LOCK: begin
        if (found_q) begin
          focus_d = best_idx_q;
          held_d  = 1'b1;
        end else begin
          resp_status = nts_pkg::STS_NONE;
        end
      end
      nts_pkg::CMD_CLEAR: begin
        focus_d = '0;
        held_d  = 1'b0;
      end
      nts_pkg::CMD_RETIRE: begin
        if (!in_range) begin
          resp_status = nts_pkg::STS_RANGE;
        end else begin
          flag_we = resp_fire;
          if (held_q && focus_q == AW'(eidx_w)) begin
            focus_d = '0;
            held_d  = 1'b0;
          end
        end
      end
      default: resp_status = nts_pkg::STS_OK;
    endcase
    // A successful insert reports its slot; anything else the focus, or zero.
    if (cmd_q == nts_pkg::CMD_INSERT && !full) begin
      resp_index = 8'(cnt_q);
    end else begin
      resp_index = held_d ? 8'(focus_d) : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nts_pkg::S_IDLE;
      cnt_q       <= '0;
      focus_q     <= '0;
      held_q      <= 1'b0;
      scan_q      <= '0;
      rd_v_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue_v;
      if (accept) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (issue_v) scan_q <= scan_q + CNTW'(1);
        if (dist_v && better) found_q <= 1'b1;
      end
      if (resp_fire) begin
        cnt_q       <= cnt_d;
        focus_q     <= focus_d;
        held_q      <= held_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command capture and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= nts_pkg::cmd_e'(cmd_i);
      qx_q   <= ext_x[CW-1:0];
      qy_q   <= ext_y[CW-1:0];
      qz_q   <= ext_z[CW-1:0];
      tgt_q  <= is_target_i;
      eidx_q <= entry_index_i;
    end
    if (resp_fire) begin
      out_status_q <= resp_status;
      out_index_q  <= resp_index;
      out_focus_q  <= held_d;
    end
    rd_idx_q <= rd_addr;
    if (dist_v && better) begin
      best_q     <= dist_val;
      best_idx_q <= dist_idx;
    end
  end

  // Point memory: written on insert, read once per cycle during a scan.
  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[AW'(cnt_q)] <= {qx_q, qy_q, qz_q};
    rd_pt_q <= pt_mem[rd_addr];
  end

  // Target flags: written on insert and retire, read alongside the points.
  always_ff @(posedge clk_i) begin
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
    rd_flag_q <= flag_mem[rd_addr];
  end

  nts_dist #(
    .CW (CW),
    .AW (AW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q && rd_flag_q),
    .idx_i   (rd_idx_q),
    .px_i    (rd_pt_q[3*CW-1:2*CW]),
    .py_i    (rd_pt_q[2*CW-1:CW]),
    .pz_i    (rd_pt_q[CW-1:0]),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .qz_i    (qz_q),
    .valid_o (dist_v),
    .idx_o   (dist_idx),
    .dist_o  (dist_val),
    .busy_o  (dist_busy)
  );

  // Entries arrive in index order, so a strict compare keeps the lowest
  // index on a tie.
  assign better = !found_q || (dist_val < best_q);

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign index_o       = out_index_q;
  assign focus_valid_o = out_focus_q;

  // The fill count never passes the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  // With no focus held, the focus index rests at zero.
  a_focus_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> focus_q == '0)
    else $error("focus index set without a focus");

  // A new result only appears after the response state.
  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == nts_pkg::S_RESP))
    else $error("result loaded outside the response state");

  // Every distance scored comes during a scan and belongs to a filled entry.
  a_dist_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_v |-> (state_q == nts_pkg::S_SCAN) && (CNTW'(dist_idx) < cnt_q))
    else $error("distance result outside the scan or the table");

endmodule

// File: dv/nts_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nts_tb_pkg: scoreboard for the nearest target search testbench
// Keeps its own copy of the point table and focus, works out the result of
// every accepted command and checks the results that leave the block in order.
// ----------------------------------------------------------------------------
package nts_tb_pkg;

  localparam int unsigned TableDepth = 256;

  typedef struct packed {
    nts_pkg::status_e status;
    logic [7:0]       index;
    logic             focus_valid;
  } nts_result_t;

  class target_table_board;
    logic signed [15:0] pt_x [TableDepth];
    logic signed [15:0] pt_y [TableDepth];
    logic signed [15:0] pt_z [TableDepth];
    bit                 pt_live [TableDepth];
    int unsigned        fill;
    bit [7:0]           focus;
    bit                 held;
    nts_result_t        owed_results[$];
    int unsigned        errors;

    function new();
      fill   = 0;
      focus  = '0;
      held   = 1'b0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // Exact squared distance along one axis.
    static function longint axis_sq(logic signed [15:0] a, logic signed [15:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
    endfunction

    // Applies one accepted command to the table and queues the result it owes.
    function void note_command(nts_pkg::cmd_e cmd, logic signed [15:0] x,
                               logic signed [15:0] y, logic signed [15:0] z,
                               logic tgt, logic [7:0] idx);
      nts_result_t r;
      longint      best;
      longint      d;
      bit          found;
      int unsigned best_i;
      bit          slot_out;
      bit [7:0]    slot;
      r.status = nts_pkg::STS_OK;
      slot_out = 1'b0;
      slot     = '0;
      found    = 1'b0;
      best     = 0;
      best_i   = 0;
      case (cmd)
        nts_pkg::CMD_INSERT: begin
          if (fill >= TableDepth) begin
            r.status = nts_pkg::STS_FULL;
          end else begin
            pt_x[fill]    = x;
            pt_y[fill]    = y;
            pt_z[fill]    = z;
            pt_live[fill] = tgt;
            slot          = 8'(fill);
            slot_out      = 1'b1;
            fill++;
          end
        end
        nts_pkg::CMD_LOCK: begin
          for (int unsigned i = 0; i < fill; i++) begin
            if (pt_live[i]) begin
              d = axis_sq(pt_x[i], x) + axis_sq(pt_y[i], y) + axis_sq(pt_z[i], z);
              // Strict compare keeps the lowest index on a tie.
              if (!found || d < best) begin
                found  = 1'b1;
                best   = d;
                best_i = i;
              end
            end
          end
          if (found) begin
            focus = 8'(best_i);
            held  = 1'b1;
          end else begin
            r.status = nts_pkg::STS_NONE;
          end
        end
        nts_pkg::CMD_CLEAR: begin
          held  = 1'b0;
          focus = '0;
        end
        default: begin
          if (idx >= fill) begin
            r.status = nts_pkg::STS_RANGE;
          end else begin
            pt_live[idx] = 1'b0;
            if (held && focus == idx) begin
              held  = 1'b0;
              focus = '0;
            end
          end
        end
      endcase
      r.index       = slot_out ? slot : (held ? focus : 8'd0);
      r.focus_valid = held;
      owed_results.push_back(r);
    endfunction

    // Compares one accepted result with the oldest owed result.
    function void check_result(logic [1:0] status, logic [7:0] index, logic focus_valid);
      nts_result_t e;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: status %0d index %0d focus_valid %0b",
               status, index, focus_valid);
        errors++;
        return;
      end
      e = owed_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (index !== e.index) begin
        $error("index: expected %0d, actual %0d", e.index, index);
        errors++;
      end
      if (focus_valid !== e.focus_valid) begin
        $error("focus_valid: expected %0b, actual %0b", e.focus_valid, focus_valid);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: dv/nearest_target_search_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_target_search_top_test: self-checking bench for the target search
// Drives insert, lock-on, clear and retire commands through the valid/stall
// input channel, first as a short directed list and then at random, and checks
// every result transfer against a scoreboard that tracks the table and focus.
// ----------------------------------------------------------------------------
module nearest_target_search_top_test;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         cmd_i;
  logic signed [15:0] pos_x_i;
  logic signed [15:0] pos_y_i;
  logic signed [15:0] pos_z_i;
  logic               is_target_i;
  logic [7:0]         entry_index_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [7:0]         index_o;
  logic               focus_valid_o;

  // Chance, in percent per cycle, that the sender holds back or the receiver
  // stalls. The main sequence changes these between phases.
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;

  nts_tb_pkg::target_table_board board;

  nearest_target_search_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .is_target_i   (is_target_i),
    .entry_index_i (entry_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .index_o       (index_o),
    .focus_valid_o (focus_valid_o)
  );

  // 4 ns clock, starting low so that the first rising edge comes at 2 ns.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // The receiver stalls at random. The stall is updated at the rising edge with
  // a nonblocking assignment, so the monitor below always sees the value that
  // was in force during the cycle that just ended.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // A result transfer happens at an edge where valid is high and stall low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(status_o, index_o, focus_valid_o);
    end
  end

  // Offers one command and returns at the edge where it is taken. A random
  // number of idle cycles may come first; when none does, valid simply stays
  // high from the previous transfer and only the payload changes.
  task automatic send_command(nts_pkg::cmd_e cmd, logic signed [15:0] x,
                              logic signed [15:0] y, logic signed [15:0] z,
                              logic tgt, logic [7:0] idx);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    pos_x_i       <= x;
    pos_y_i       <= y;
    pos_z_i       <= z;
    is_target_i   <= tgt;
    entry_index_i <= idx;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    board.note_command(cmd, x, y, z, tgt, idx);
  endtask

  // Holds the sender back until every owed result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One random command. While the table still has room, inserts dominate so
  // that it fills up during the run; once it is full, lock-on and retire take
  // over so that long scans over the whole table get exercised.
  task automatic random_command();
    nts_pkg::cmd_e      cmd;
    int unsigned        roll;
    int unsigned        pick;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               tgt;
    logic [7:0]         idx;
    roll = $urandom_range(0, 99);
    if (board.fill < nts_tb_pkg::TableDepth) begin
      if (roll < 72)      cmd = nts_pkg::CMD_INSERT;
      else if (roll < 86) cmd = nts_pkg::CMD_LOCK;
      else if (roll < 90) cmd = nts_pkg::CMD_CLEAR;
      else                cmd = nts_pkg::CMD_RETIRE;
    end else begin
      if (roll < 15)      cmd = nts_pkg::CMD_INSERT;
      else if (roll < 55) cmd = nts_pkg::CMD_LOCK;
      else if (roll < 65) cmd = nts_pkg::CMD_CLEAR;
      else                cmd = nts_pkg::CMD_RETIRE;
    end
    // Coordinates: full range, a tight cluster around the origin that makes
    // distance ties common, or a point close to one already stored.
    roll = $urandom_range(0, 99);
    if (roll < 40 || board.fill == 0) begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
    end else if (roll < 70) begin
      x = 16'($urandom_range(0, 8) - 4);
      y = 16'($urandom_range(0, 8) - 4);
      z = 16'($urandom_range(0, 8) - 4);
    end else begin
      pick = $urandom_range(0, board.fill - 1);
      x = board.pt_x[pick] + 16'($urandom_range(0, 2) - 1);
      y = board.pt_y[pick] + 16'($urandom_range(0, 2) - 1);
      z = board.pt_z[pick] + 16'($urandom_range(0, 2) - 1);
    end
    tgt = ($urandom_range(0, 99) < 75);
    // Retire mostly hits a stored entry; the rest may fall beyond the count.
    if (board.fill != 0 && $urandom_range(0, 99) < 80) begin
      idx = 8'($urandom_range(0, board.fill - 1));
    end else begin
      idx = 8'($urandom);
    end
    send_command(cmd, x, y, z, tgt, idx);
  endtask

  initial begin
    board         = new();
    snd_idle_pct  = 23;
    rcv_idle_pct  = 69;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = nts_pkg::CMD_INSERT;
    pos_x_i       = '0;
    pos_y_i       = '0;
    pos_z_i       = '0;
    is_target_i   = 1'b0;
    entry_index_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An empty table first: lock-on finds nothing, retire is
    // out of range and clear works with no focus held.
    send_command(nts_pkg::CMD_LOCK,   16'sd0, 16'sd0, 16'sd0, 1'b1, 8'd0);
    send_command(nts_pkg::CMD_RETIRE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0);
    send_command(nts_pkg::CMD_CLEAR,  16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0);
    // Points at both corners of the coordinate range, a non-target at the
    // origin and two targets at equal distance from it.
    send_command(nts_pkg::CMD_INSERT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 8'd0);
    send_command(nts_pkg::CMD_INSERT, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 8'd0);
    send_command(nts_pkg::CMD_INSERT, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'hFF);
    send_command(nts_pkg::CMD_INSERT, 16'sd1, 16'sd0, 16'sd0, 1'b1, 8'h00);
    send_command(nts_pkg::CMD_INSERT, -16'sd1, 16'sd0, 16'sd0, 1'b1, 8'hFF);
    // The non-target at the origin is skipped and the tie goes to entry 3.
    send_command(nts_pkg::CMD_LOCK,   16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0);
    send_command(nts_pkg::CMD_LOCK,   16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 8'd0);
    send_command(nts_pkg::CMD_LOCK,   16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 8'd0);
    // Each axis at the largest distance from one of the two corner points.
    send_command(nts_pkg::CMD_LOCK,   16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1, 8'd0);
    // Retiring a non-target keeps the focus; retiring the focus drops it.
    send_command(nts_pkg::CMD_RETIRE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd2);
    send_command(nts_pkg::CMD_LOCK,   16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 8'd0);
    send_command(nts_pkg::CMD_RETIRE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd0);
    send_command(nts_pkg::CMD_LOCK,   16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 8'd0);
    // Retire just at the count and far beyond it.
    send_command(nts_pkg::CMD_RETIRE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd5);
    send_command(nts_pkg::CMD_RETIRE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd200);
    send_command(nts_pkg::CMD_CLEAR,  16'sh5555, 16'shAAAA, 16'sh5555, 1'b1, 8'hAA);
    send_command(nts_pkg::CMD_INSERT, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, 8'h55);
    // Retire every target left, then lock-on has nothing to find.
    send_command(nts_pkg::CMD_RETIRE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd1);
    send_command(nts_pkg::CMD_RETIRE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd3);
    send_command(nts_pkg::CMD_RETIRE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 8'd4);
    send_command(nts_pkg::CMD_LOCK,   16'sd1, 16'sd0, 16'sd0, 1'b0, 8'd0);

    // Random part in three phases of idling. Before each phase the sender
    // waits until every owed result has come out.
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          snd_idle_pct = 23;
          rcv_idle_pct = 69;
        end
        1: begin
          snd_idle_pct = 69;
          rcv_idle_pct = 23;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      repeat (140) random_command();
    end

    // Wait for the last results, then long enough for a full-table scan to
    // show any result that should not be there.
    drain();
    repeat (320) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("nearest_target_search_top: match");
    end else begin
      $display("nearest_target_search_top: mismatch");
    end
    $finish;
  end

  // Safety limit, several times the slowest correct run.
  initial begin
    #4_000_000;
    $display("nearest_target_search_top: mismatch");
    $finish;
  end

endmodule
